/* hdl/omni_wheel_inverse_kinematics_macros.svh */
// assertion macros for the omni wheel inverse kinematics block
// used by the port checker, no other dependencies
`ifndef OMNI_WHEEL_INVERSE_KINEMATICS_MACROS_SVH
`define OMNI_WHEEL_INVERSE_KINEMATICS_MACROS_SVH

// checked only while out of reset
`define OWIK_ASSERT_IFF(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define OWIK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/owik_pkg.sv */
// types, constants and the arctangent table of the omni wheel kinematics
// no dependencies
package owik_pkg;

  localparam int CfgW   = 12;
  localparam int XW     = 48;
  localparam int ZW     = 32;
  localparam int TabLen = 24;
  localparam int LW     = 34;
  localparam int NW     = 46;
  localparam int QW     = 29;
  localparam int Lanes  = 4;
  localparam int PipeFixedLat = QW + 6;

  localparam logic signed [XW-1:0] GainQ30   = 48'sd652032874;
  localparam logic [15:0]          CoupleQ16 = 16'd46341;
  localparam logic [CfgW-1:0]      BodyReset  = 12'd500;
  localparam logic [CfgW-1:0]      WheelReset = 12'd100;

  typedef enum logic [0:0] {
    REG_BODY_DIAM  = 1'b0,
    REG_WHEEL_DIAM = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic signed [15:0] speed;
    logic signed [15:0] heading;
    logic signed [15:0] turn_rate;
  } cmd_t;

  typedef struct packed {
    logic signed [23:0] wheel_speed_a;
    logic signed [23:0] wheel_speed_b;
    logic signed [23:0] wheel_speed_c;
    logic signed [23:0] wheel_speed_d;
    logic               saturated;
  } res_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 flip;
    logic signed [15:0]   turn;
  } rot_t;

  typedef struct packed {
    logic          neg;
    logic [NW-2:0] mag;
  } num_t;

  typedef struct packed {
    logic          neg;
    logic [NW-2:0] rem;
    logic [QW-1:0] q;
  } div_t;

  // atan(2^-i) in 2^-22 degree
  function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] idx);
    logic signed [ZW-1:0] r;
    unique case (idx)
      5'd0:  r = 32'sd188743680;
      5'd1:  r = 32'sd111421900;
      5'd2:  r = 32'sd58872272;
      5'd3:  r = 32'sd29884485;
      5'd4:  r = 32'sd15000234;
      5'd5:  r = 32'sd7507429;
      5'd6:  r = 32'sd3754631;
      5'd7:  r = 32'sd1877430;
      5'd8:  r = 32'sd938729;
      5'd9:  r = 32'sd469366;
      5'd10: r = 32'sd234683;
      5'd11: r = 32'sd117342;
      5'd12: r = 32'sd58671;
      5'd13: r = 32'sd29335;
      5'd14: r = 32'sd14668;
      5'd15: r = 32'sd7334;
      5'd16: r = 32'sd3667;
      5'd17: r = 32'sd1833;
      5'd18: r = 32'sd917;
      5'd19: r = 32'sd458;
      5'd20: r = 32'sd229;
      5'd21: r = 32'sd115;
      5'd22: r = 32'sd57;
      5'd23: r = 32'sd29;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/owik_front.sv */
// heading reduction and speed gain scaling, first pipeline stage
// depends on owik_pkg
module owik_front import owik_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  cmd_t cmd_i,
  output logic valid_o,
  output rot_t rot_o
);

  logic [17:0]        hs;
  logic [16:0]        a0, a1;
  logic signed [15:0] a2;
  logic               flip;
  logic signed [XW-1:0] spd;
  rot_t rot_d, rot_q;
  logic valid_q;

  always_comb begin
    hs = {{2{cmd_i.heading[15]}}, cmd_i.heading} + 18'd46080;
    a0 = hs[16:0];
    priority if (a0 >= 17'd69120) a1 = a0 - 17'd69120;
    else if (a0 >= 17'd46080) a1 = a0 - 17'd46080;
    else if (a0 >= 17'd23040) a1 = a0 - 17'd23040;
    else a1 = a0;
    a2 = 16'(a1);
    if (a1 >= 17'd17280) a2 = 16'(a1) - 16'sd23040;
    flip = 1'b0;
    if (a2 > 16'sd5760) begin
      a2   = a2 - 16'sd11520;
      flip = 1'b1;
    end
    spd        = XW'(cmd_i.speed);
    rot_d.x    = spd * GainQ30;
    rot_d.y    = '0;
    rot_d.z    = {a2, 16'h0000};
    rot_d.flip = flip;
    rot_d.turn = cmd_i.turn_rate;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    rot_q <= rot_d;
  end

  assign valid_o = valid_q;
  assign rot_o   = rot_q;

endmodule

/* hdl/owik_cordic.sv */
// rotation mode cordic, one micro-rotation per register stage
// depends on owik_pkg
module owik_cordic import owik_pkg::*; #(
  parameter int ROTATION_STAGES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  rot_t rot_i,
  output logic valid_o,
  output rot_t rot_o
);

  localparam int NS = (ROTATION_STAGES > TabLen) ? TabLen : ROTATION_STAGES;

  rot_t src [NS];
  rot_t st_d [NS];
  rot_t st_q [NS];
  logic [NS-1:0] vld_q;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign src[k] = rot_i;
    end else begin : g_next
      assign src[k] = st_q[k-1];
    end

    always_comb begin
      logic signed [XW-1:0] xs, ys, dx, dy;
      logic signed [ZW-1:0] zs, at;
      xs = src[k].x;
      ys = src[k].y;
      zs = src[k].z;
      dx = ys >>> k;
      dy = xs >>> k;
      at = atan_lut(5'(k));
      st_d[k] = src[k];
      if (!zs[ZW-1]) begin
        st_d[k].x = xs - dx;
        st_d[k].y = ys + dy;
        st_d[k].z = zs - at;
      end else begin
        st_d[k].x = xs + dx;
        st_d[k].y = ys - dy;
        st_d[k].z = zs + at;
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[k] <= st_d[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else vld_q <= {vld_q[NS-2:0], valid_i};
  end

  assign valid_o = vld_q[NS-1];
  assign rot_o   = st_q[NS-1];

endmodule

/* hdl/owik_mix.sv */
// wheel coupling: fold, diagonal sums, split 0.70711 product and lever term
// depends on owik_pkg
module owik_mix import owik_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  rot_t            rot_i,
  input  logic [CfgW-1:0] body_i,
  output logic            valid_o,
  output num_t [Lanes-1:0] num_o
);

  logic [3:0] vld_q;

  // stage 1
  logic signed [XW-1:0] xf, yf;
  logic signed [XW:0]   p_d, m_d, p_q, m_q;
  logic signed [28:0]   lev_d, lev1_q, lev2_q, lev3_q;

  always_comb begin
    xf    = rot_i.flip ? -rot_i.x : rot_i.x;
    yf    = rot_i.flip ? -rot_i.y : rot_i.y;
    p_d   = {xf[XW-1], xf} + {yf[XW-1], yf};
    m_d   = {xf[XW-1], xf} - {yf[XW-1], yf};
    lev_d = 29'($signed({1'b0, body_i})) * 29'(rot_i.turn);
  end

  // stage 2
  logic [39:0]        plo_q, mlo_q;
  logic signed [41:0] phi_q, mhi_q;
  logic signed [41:0] cpl;

  assign cpl = 42'($signed({1'b0, CoupleQ16}));

  // stage 3
  logic signed [65:0] pp, pm;
  logic signed [65:0] s [Lanes];
  logic signed [LW-1:0] l_q [Lanes];

  always_comb begin
    pp   = (66'(phi_q) <<< 24) + 66'(plo_q);
    pm   = (66'(mhi_q) <<< 24) + 66'(mlo_q);
    s[0] = -pp;
    s[1] = -pm;
    s[2] = pp;
    s[3] = pm;
  end

  // stage 4
  num_t [Lanes-1:0] num_d, num_q;

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      logic signed [NW-1:0] n;
      n = NW'(l_q[l]) * NW'(11'd2000) + (NW'(lev3_q) <<< 16);
      num_d[l].neg = n[NW-1];
      num_d[l].mag = n[NW-1] ? (NW-1)'(-n) : (NW-1)'(n);
    end
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    m_q    <= m_d;
    lev1_q <= lev_d;
    plo_q  <= 40'(p_q[23:0]) * 40'(CoupleQ16);
    mlo_q  <= 40'(m_q[23:0]) * 40'(CoupleQ16);
    phi_q  <= 42'($signed(p_q[XW:24])) * cpl;
    mhi_q  <= 42'($signed(m_q[XW:24])) * cpl;
    lev2_q <= lev1_q;
    for (int l = 0; l < Lanes; l++) begin
      l_q[l] <= s[l][LW+29:30];
    end
    lev3_q <= lev2_q;
    num_q  <= num_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else vld_q <= {vld_q[2:0], valid_i};
  end

  assign valid_o = vld_q[3];
  assign num_o   = num_q;

endmodule

/* hdl/owik_div.sv */
// pipelined restoring divide by the wheel diameter, one quotient bit per stage,
// then sign and saturation into the result register; depends on owik_pkg
module owik_div import owik_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  num_t [Lanes-1:0] num_i,
  input  logic [CfgW-1:0]  wheel_i,
  output logic             valid_o,
  output res_t             res_o
);

  logic [NW-2:0] dv;
  assign dv = (NW-1)'({wheel_i, 16'h0000});

  div_t [Lanes-1:0] src [QW];
  div_t [Lanes-1:0] st_d [QW];
  div_t [Lanes-1:0] st_q [QW];
  logic [QW-1:0] vld_q;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    if (k == 0) begin : g_first
      for (genvar l = 0; l < Lanes; l++) begin : g_lane
        assign src[k][l].neg = num_i[l].neg;
        assign src[k][l].rem = num_i[l].mag;
        assign src[k][l].q   = '0;
      end
    end else begin : g_next
      assign src[k] = st_q[k-1];
    end

    always_comb begin
      st_d[k] = src[k];
      for (int l = 0; l < Lanes; l++) begin
        if ((src[k][l].rem >> B) >= dv) begin
          st_d[k][l].rem = src[k][l].rem - (dv << B);
          st_d[k][l].q   = src[k][l].q | (QW'(1) << B);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[k] <= st_d[k];
    end
  end

  logic signed [23:0] w [Lanes];
  logic [Lanes-1:0]   sat;
  res_t res_d, res_q;
  logic valid_q;

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      logic [QW-1:0] q;
      q      = st_q[QW-1][l].q;
      sat[l] = 1'b0;
      if (st_q[QW-1][l].neg) begin
        if (q > QW'(24'd8388608)) begin
          w[l]   = 24'sh800000;
          sat[l] = 1'b1;
        end else begin
          w[l] = 24'(~q + 1'b1);
        end
      end else begin
        if (q > QW'(24'd8388607)) begin
          w[l]   = 24'sh7fffff;
          sat[l] = 1'b1;
        end else begin
          w[l] = 24'(q);
        end
      end
    end
    res_d.wheel_speed_a = w[0];
    res_d.wheel_speed_b = w[1];
    res_d.wheel_speed_c = w[2];
    res_d.wheel_speed_d = w[3];
    res_d.saturated     = |sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      vld_q   <= {vld_q[QW-2:0], valid_i};
      valid_q <= vld_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

/* hdl/omni_wheel_inverse_kinematics.sv */
// Four-wheel omni base inverse kinematics. A command beat (start_i) is taken
// on every clock; busy_o stays low. Each command gives one result beat on
// result_o, marked by valid_o for one cycle, after it has passed through one
// stage of heading reduction, one cordic stage per micro-rotation, four
// coupling stages, 29 divider stages (one quotient bit each) and the output
// register. The receiver cannot stall. Configuration writes take effect at
// once and belong in idle time.
// depends on owik_pkg, owik_front, owik_cordic, owik_mix, owik_div
module omni_wheel_inverse_kinematics import owik_pkg::*; #(
  parameter int ROTATION_STAGES = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  cmd_t            cmd_i,
  output logic            valid_o,
  output res_t            result_o,
  input  logic            cfg_we_i,
  input  reg_idx_e        cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i
);

  logic [CfgW-1:0] body_q, wheel_q, wheel_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      body_q  <= BodyReset;
      wheel_q <= WheelReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BODY_DIAM:  body_q  <= cfg_data_i;
        REG_WHEEL_DIAM: wheel_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign wheel_eff = (wheel_q == '0) ? CfgW'(1) : wheel_q;
  assign busy_o    = 1'b0;

  logic fr_vld, co_vld, mx_vld;
  rot_t fr_rot, co_rot;
  num_t [Lanes-1:0] mx_num;

  owik_front u_front (
    .clk_i, .rst_ni,
    .valid_i (start_i),
    .cmd_i   (cmd_i),
    .valid_o (fr_vld),
    .rot_o   (fr_rot)
  );

  owik_cordic #(.ROTATION_STAGES(ROTATION_STAGES)) u_cordic (
    .clk_i, .rst_ni,
    .valid_i (fr_vld),
    .rot_i   (fr_rot),
    .valid_o (co_vld),
    .rot_o   (co_rot)
  );

  owik_mix u_mix (
    .clk_i, .rst_ni,
    .valid_i (co_vld),
    .rot_i   (co_rot),
    .body_i  (body_q),
    .valid_o (mx_vld),
    .num_o   (mx_num)
  );

  owik_div u_div (
    .clk_i, .rst_ni,
    .valid_i (mx_vld),
    .num_i   (mx_num),
    .wheel_i (wheel_eff),
    .valid_o (valid_o),
    .res_o   (result_o)
  );

endmodule

/* hdl/owik_checker.sv */
// port level checks of the omni wheel kinematics block, bound to the top level
// depends on owik_pkg and omni_wheel_inverse_kinematics_macros.svh
`include "omni_wheel_inverse_kinematics_macros.svh"

module owik_checker import owik_pkg::*; #(
  parameter int ROTATION_STAGES = 16
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic valid_o,
  input res_t result_o
);

  localparam int NS  = (ROTATION_STAGES > TabLen) ? TabLen : ROTATION_STAGES;
  localparam int Lat = NS + PipeFixedLat;

  logic on_rail;

  assign on_rail = (result_o.wheel_speed_a == 24'sh7fffff) ||
                   (result_o.wheel_speed_a == 24'sh800000) ||
                   (result_o.wheel_speed_b == 24'sh7fffff) ||
                   (result_o.wheel_speed_b == 24'sh800000) ||
                   (result_o.wheel_speed_c == 24'sh7fffff) ||
                   (result_o.wheel_speed_c == 24'sh800000) ||
                   (result_o.wheel_speed_d == 24'sh7fffff) ||
                   (result_o.wheel_speed_d == 24'sh800000);

  `OWIK_ASSERT_ALWAYS(a_never_busy, clk_i, !busy_o, "command beat refused")

  `OWIK_ASSERT_IFF(a_beat_cmd, clk_i, rst_ni, valid_o |-> $past(start_i, Lat), "orphan result beat")

  `OWIK_ASSERT_IFF(a_sat_at_rail, clk_i, rst_ni, (valid_o && result_o.saturated) |-> on_rail, "no clip")

endmodule

bind omni_wheel_inverse_kinematics owik_checker #(
  .ROTATION_STAGES(ROTATION_STAGES)
) u_owik_checker (.*);

/* tb/sv/owik_wheel_checker.sv */
`timescale 1ns / 1ps
// wheel speed checker for the omni wheel inverse kinematics block
// watches command, result and register ports; depends on owik_pkg
module owik_wheel_checker import owik_pkg::*; #(
  parameter int ROT_STAGES = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            busy_i,
  input  cmd_t            cmd_i,
  input  logic            valid_i,
  input  res_t            result_i,
  input  logic            cfg_we_i,
  input  reg_idx_e        cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  output int              errors_o,
  output int              pending_o
);

  localparam longint ArcTan [24] = '{
    188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
    3754631, 1877430, 938729, 469366, 234683, 117342,
    58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29
  };

  logic [CfgW-1:0] body_diam, wheel_diam;
  res_t            wheel_q[$];
  int              errors;

  assign errors_o  = errors;
  assign pending_o = wheel_q.size();

  function automatic res_t wheel_speeds(cmd_t c, logic [CfgW-1:0] bd, logic [CfgW-1:0] wd);
    longint a, x, y, z, dx, dy, den, lever, s, lin, n, q;
    bit     flip;
    int     st;
    res_t   r;
    flip = 0;
    r = '0;
    a = longint'(c.heading) % 23040;
    if (a < 0) a += 23040;
    if (a >= 17280) a -= 23040;
    if (a > 5760) begin
      a -= 11520;
      flip = 1;
    end
    x = longint'(c.speed) * 652032874;
    y = 0;
    z = a * 65536;
    st = (ROT_STAGES > 24) ? 24 : ROT_STAGES;
    for (int i = 0; i < st; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ArcTan[i];
      end else begin
        x += dx;
        y -= dy;
        z += ArcTan[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    den = longint'((wd == 0) ? 1 : wd) * 65536;
    lever = longint'(bd) * longint'(c.turn_rate) * 65536;
    for (int w = 0; w < 4; w++) begin
      case (w)
        0: s = -x - y;
        1: s = -x + y;
        2: s = x + y;
        default: s = x - y;
      endcase
      lin = (s * 46341) >>> 30;
      n = 2000 * lin + lever;
      q = n / den;
      if (q > 8388607) begin
        q = 8388607;
        r.saturated = 1'b1;
      end else if (q < -8388608) begin
        q = -8388608;
        r.saturated = 1'b1;
      end
      case (w)
        0: r.wheel_speed_a = q[23:0];
        1: r.wheel_speed_b = q[23:0];
        2: r.wheel_speed_c = q[23:0];
        default: r.wheel_speed_d = q[23:0];
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      body_diam  = BodyReset;
      wheel_diam = WheelReset;
      wheel_q.delete();
      errors = 0;
    end else begin
      if (valid_i) begin
        if (wheel_q.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          want = wheel_q.pop_front();
          if (result_i.wheel_speed_a !== want.wheel_speed_a)
            report_mismatch("wheel a", result_i.wheel_speed_a, want.wheel_speed_a);
          if (result_i.wheel_speed_b !== want.wheel_speed_b)
            report_mismatch("wheel b", result_i.wheel_speed_b, want.wheel_speed_b);
          if (result_i.wheel_speed_c !== want.wheel_speed_c)
            report_mismatch("wheel c", result_i.wheel_speed_c, want.wheel_speed_c);
          if (result_i.wheel_speed_d !== want.wheel_speed_d)
            report_mismatch("wheel d", result_i.wheel_speed_d, want.wheel_speed_d);
          if (result_i.saturated !== want.saturated)
            report_mismatch("saturated", result_i.saturated, want.saturated);
        end
      end
      if (start_i && !busy_i)
        wheel_q.push_back(wheel_speeds(cmd_i, body_diam, wheel_diam));
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_BODY_DIAM) body_diam = cfg_data_i;
        else if (cfg_idx_i == REG_WHEEL_DIAM) wheel_diam = cfg_data_i;
      end
    end
  end

endmodule

/* tb/sv/tb_omni_wheel_inverse_kinematics.sv */
`timescale 1ns / 1ps
// top of the omni wheel inverse kinematics testbench: clock, reset, stimulus
// depends on owik_pkg, omni_wheel_inverse_kinematics, owik_wheel_checker
module tb_omni_wheel_inverse_kinematics;
  import owik_pkg::*;

  localparam int Latency = 24 + 35 + 10;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  cmd_t            cmd = '0;
  logic            valid;
  res_t            result;
  logic            cfg_we = 1'b0;
  reg_idx_e        cfg_idx = REG_BODY_DIAM;
  logic [CfgW-1:0] cfg_data = '0;
  int              errors, pending;
  int              idle_pct;

  always #6 clk = ~clk;

  omni_wheel_inverse_kinematics dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy), .cmd_i(cmd),
    .valid_o(valid), .result_o(result), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data)
  );

  owik_wheel_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy), .cmd_i(cmd),
    .valid_i(valid), .result_i(result), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .errors_o(errors), .pending_o(pending)
  );

  // called at a falling edge, returns at a falling edge
  task automatic send_cmd(logic [15:0] sp, logic [15:0] hd, logic [15:0] tr);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    cmd   <= '{speed: sp, heading: hd, turn_rate: tr};
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic write_regs(logic [CfgW-1:0] bd, logic [CfgW-1:0] wd);
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (Latency) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= REG_BODY_DIAM;
    cfg_data <= bd;
    @(negedge clk);
    cfg_idx <= REG_WHEEL_DIAM;
    cfg_data <= wd;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [15:0] sp, hd;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    idle_pct = 28;
    // directed beats at reset settings
    send_cmd(16'h7fff, 16'd0, 16'd0);
    send_cmd(16'h8000, 16'd0, 16'd0);
    send_cmd(16'h7fff, 16'd5760, 16'd0);
    send_cmd(16'h7fff, -16'sd5760, 16'd0);
    send_cmd(16'h7fff, 16'd11520, 16'd0);
    send_cmd(16'h7fff, 16'd17280, 16'd0);
    send_cmd(16'h7fff, 16'd23040, 16'd0);
    send_cmd(16'h8000, 16'h8000, 16'h8000);
    send_cmd(16'h7fff, 16'h7fff, 16'h7fff);
    send_cmd(16'd0, 16'd2880, 16'h7fff);
    send_cmd(16'd0, 16'd0, 16'h8000);
    send_cmd(16'hffff, 16'hffff, 16'hffff);
    send_cmd(16'd1000, 16'd5761, 16'd100);
    send_cmd(16'd1000, 16'd17279, -16'sd100);
    write_regs(12'd0, 12'd0);
    send_cmd(16'h7fff, 16'd2880, 16'h7fff);
    send_cmd(16'h8000, 16'd8640, 16'h8000);
    write_regs(12'hfff, 12'd1);
    send_cmd(16'h7fff, 16'd1440, 16'h7fff);
    send_cmd(16'h8000, 16'd0, 16'h7fff);
    write_regs(12'd1, 12'hfff);
    send_cmd(16'h7fff, 16'd1440, 16'h8000);
    for (int ph = 0; ph < 6; ph++) begin
      idle_pct = (ph < 2) ? 28 : (ph < 4) ? 73 : 0;
      case (ph)
        0: write_regs(12'd500, 12'd100);
        1: write_regs(12'hfff, 12'd1);
        2: write_regs(12'd0, 12'd0);
        3: write_regs(12'd1, 12'hfff);
        default: write_regs(12'($urandom_range(4095)), 12'($urandom_range(4095)));
      endcase
      for (int k = 0; k < 215; k++) begin
        sp = 16'(($urandom_range(3) == 0) ? $urandom_range(255) - 128 : $urandom);
        hd = 16'(($urandom_range(3) == 0)
                 ? 5760 * $urandom_range(8) - 23040 + $urandom_range(2) - 1
                 : $urandom);
        send_cmd(sp, hd, 16'($urandom));
      end
    end
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (Latency) @(negedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/owik_pkg.sv
hdl/owik_front.sv
hdl/owik_cordic.sv
hdl/owik_mix.sv
hdl/owik_div.sv
hdl/omni_wheel_inverse_kinematics.sv
hdl/owik_checker.sv
tb/sv/owik_wheel_checker.sv
tb/sv/tb_omni_wheel_inverse_kinematics.sv
